// ----- rtl/core/dlrs_pkg.sv -----
// ----------------------------------------------------------------------------
// dlrs_pkg
// Shared constants, types and helper functions of the decimal LSD radix
// sorter: value limits, decimal digit conversion, controller/datapath links.
// ----------------------------------------------------------------------------
package dlrs_pkg;

   localparam int MAX_ITEMS_DEF    = 64;
   localparam int DIGIT_PASSES_DEF = 4;

   localparam int RADIX     = 10;
   localparam int VALUE_W   = 14;
   localparam int VALUE_MAX = 9999;
   localparam int DIGIT_W   = 4;
   localparam int BCD_W     = 16;
   localparam int PASS_W    = 2;

   // value / 100 as (value * HI_RECIP) >> HI_SHIFT, exact for 0..9999
   localparam int HI_RECIP = 5243;
   localparam int HI_SHIFT = 19;
   localparam int HI_W     = 7;
   localparam int PROD_W   = 27;

   // tens of a value below 100 as (x * TENS_RECIP) >> TENS_SHIFT
   localparam int TENS_RECIP = 205;
   localparam int TENS_SHIFT = 11;
   localparam int TENS_PW    = 15;

   typedef struct packed {
      logic               in_take;
      logic               cvt;
      logic               wr_load;
      logic               clr_cnt;
      logic               pfx_step;
      logic [DIGIT_W-1:0] pfx_digit;
      logic               rd_cnt;
      logic               rd_sct;
      logic               rd_out;
      logic               out_last;
      logic [PASS_W-1:0]  pass;
      logic               src_bank;
      logic               set_done;
   } dlrs_cmd_type;

   typedef struct packed {
      logic item_last;
      logic rsp_busy;
   } dlrs_status_type;

   // two BCD digits of a value below 100
   function automatic logic [2*DIGIT_W-1:0] bcd99(input logic [HI_W-1:0] x);
      logic [TENS_PW-1:0] prod;
      logic [DIGIT_W-1:0] tens;
      logic [HI_W-1:0]    rest;
      prod = TENS_PW'(x) * TENS_PW'(TENS_RECIP);
      tens = prod[TENS_SHIFT +: DIGIT_W];
      rest = x - HI_W'(tens) * HI_W'(RADIX);
      return {tens, rest[DIGIT_W-1:0]};
   endfunction

   function automatic logic [VALUE_W-1:0] bcd_to_bin(input logic [BCD_W-1:0] b);
      return VALUE_W'(b[15:12]) * VALUE_W'(1000) + VALUE_W'(b[11:8]) * VALUE_W'(100)
           + VALUE_W'(b[7:4]) * VALUE_W'(RADIX) + VALUE_W'(b[3:0]);
   endfunction

endpackage

// ----- rtl/core/dlrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlrs_ctrl
// Sequencer of the sorter: load, per-pass clear/count/prefix/scatter, and
// the output drain. Drives the datapath through a command struct.
// ----------------------------------------------------------------------------
module dlrs_ctrl
   import dlrs_pkg::*;
#(
   parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
   parameter int DIGIT_PASSES = DIGIT_PASSES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]     item_count,
   input  dlrs_status_type                    status,
   output dlrs_cmd_type                       cmd,
   output logic [$clog2(MAX_ITEMS)-1:0]       rd_addr
);

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);

   localparam logic [3:0] ST_LOAD = 4'd0;
   localparam logic [3:0] ST_CVT  = 4'd1;
   localparam logic [3:0] ST_WR   = 4'd2;
   localparam logic [3:0] ST_CLR  = 4'd3;
   localparam logic [3:0] ST_CNT  = 4'd4;
   localparam logic [3:0] ST_PFX  = 4'd5;
   localparam logic [3:0] ST_SCT  = 4'd6;
   localparam logic [3:0] ST_OUT  = 4'd7;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [DIGIT_W-1:0] pd_ff, pd_in;
   logic [PASS_W-1:0]  pass_ff, pass_in;
   logic               bank_ff, bank_in;
   logic               pend_ff, pend_in;
   logic               more;

   assign more      = idx_ff < item_count;
   assign req_stall = state_ff != ST_LOAD;
   assign rd_addr   = idx_ff[AW-1:0];

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pd_in    = pd_ff;
      pass_in  = pass_ff;
      bank_in  = bank_ff;
      pend_in  = 1'b0;
      cmd           = '0;
      cmd.pfx_digit = pd_ff;
      cmd.pass      = pass_ff;
      cmd.src_bank  = bank_ff;
      case (state_ff)
         ST_LOAD: begin
            cmd.in_take = req_valid;
            if (req_valid) state_in = ST_CVT;
         end
         ST_CVT: begin
            cmd.cvt  = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.wr_load = 1'b1;
            if (status.item_last) begin
               state_in = ST_CLR;
               pass_in  = '0;
               bank_in  = 1'b0;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_CLR: begin
            cmd.clr_cnt = 1'b1;
            idx_in      = '0;
            state_in    = ST_CNT;
         end
         ST_CNT: begin
            // last read's data is counted in the cycle where idx reaches n
            cmd.rd_cnt = more;
            if (more) begin
               idx_in = idx_ff + CW'(1);
            end else begin
               idx_in   = '0;
               pd_in    = '0;
               state_in = ST_PFX;
            end
         end
         ST_PFX: begin
            cmd.pfx_step = 1'b1;
            if (pd_ff == DIGIT_W'(RADIX - 1)) begin
               pd_in    = '0;
               state_in = ST_SCT;
            end else begin
               pd_in = pd_ff + DIGIT_W'(1);
            end
         end
         ST_SCT: begin
            cmd.rd_sct = more;
            if (more) begin
               idx_in = idx_ff + CW'(1);
            end else begin
               idx_in  = '0;
               pass_in = pass_ff + PASS_W'(1);
               bank_in = ~bank_ff;
               if (pass_ff == PASS_W'(DIGIT_PASSES - 1)) state_in = ST_OUT;
               else                                      state_in = ST_CLR;
            end
         end
         ST_OUT: begin
            // one read in flight at a time; issue only when the output register frees
            if (!pend_ff && more && !status.rsp_busy) begin
               cmd.rd_out   = 1'b1;
               cmd.out_last = (idx_ff + CW'(1)) == item_count;
               idx_in       = idx_ff + CW'(1);
               pend_in      = 1'b1;
            end else if (!pend_ff && !more) begin
               cmd.set_done = 1'b1;
               idx_in       = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         idx_ff   <= '0;
         pd_ff    <= '0;
         pass_ff  <= '0;
         bank_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pd_ff    <= pd_in;
         pass_ff  <= pass_in;
         bank_ff  <= bank_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ----- rtl/core/dlrs_datapath.sv -----
// ----------------------------------------------------------------------------
// dlrs_datapath
// Input conversion to BCD, two ping-pong element stores, ten digit counters
// with prefix accumulator, scatter write path and the output register.
// ----------------------------------------------------------------------------
module dlrs_datapath
   import dlrs_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [VALUE_W-1:0]                 req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [VALUE_W-1:0]                 rsp_value_res,
   output logic                               rsp_last_res,
   output logic                               rsp_dropped,
   input  dlrs_cmd_type                       cmd,
   input  logic [$clog2(MAX_ITEMS)-1:0]       rd_addr,
   output logic [$clog2(MAX_ITEMS+1)-1:0]     item_count,
   output dlrs_status_type                    status
);

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);

   // input conversion
   logic [VALUE_W-1:0] sat_val;
   logic [PROD_W-1:0]  hi_prod;
   logic [VALUE_W-1:0] v_ff;
   logic [HI_W-1:0]    hi_ff;
   logic [HI_W-1:0]    lo_ff;
   logic               last_ff;
   logic [BCD_W-1:0]   load_bcd;

   logic [CW-1:0]      item_cnt_ff;
   logic               ovf_ff;
   logic               room;

   logic [BCD_W-1:0]   bank0 [MAX_ITEMS];
   logic [BCD_W-1:0]   bank1 [MAX_ITEMS];
   logic [BCD_W-1:0]   rd0_ff, rd1_ff;
   logic [BCD_W-1:0]   rd_word;
   logic               rd_en;
   logic               rd_cnt_ff, rd_sct_ff, rd_out_ff, rd_last_ff;

   logic [CW-1:0]      counts_ff [RADIX];
   logic [CW-1:0]      acc_ff;
   logic [DIGIT_W-1:0] dg;
   logic               dg_ok;
   logic [DIGIT_W-1:0] cnt_sel;
   logic [CW-1:0]      cnt_rd;

   logic               we0, we1;
   logic [AW-1:0]      wa0;
   logic [BCD_W-1:0]   wd0;

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_last_ff;
   logic               rsp_dropped_ff;

   assign sat_val  = (req_value > VALUE_W'(VALUE_MAX)) ? VALUE_W'(VALUE_MAX) : req_value;
   assign hi_prod  = PROD_W'(sat_val) * PROD_W'(HI_RECIP);
   assign load_bcd = {bcd99(hi_ff), bcd99(lo_ff)};
   assign room     = item_cnt_ff < CW'(MAX_ITEMS);

   always_ff @(posedge clock) begin
      if (cmd.in_take) begin
         v_ff    <= sat_val;
         hi_ff   <= hi_prod[HI_SHIFT +: HI_W];
         last_ff <= req_last;
      end
      if (cmd.cvt) lo_ff <= HI_W'(v_ff - VALUE_W'(hi_ff) * VALUE_W'(100));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
      end else if (cmd.set_done) begin
         item_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
      end else if (cmd.wr_load) begin
         if (room) item_cnt_ff <= item_cnt_ff + CW'(1);
         else      ovf_ff      <= 1'b1;
      end
   end

   assign item_count       = item_cnt_ff;
   assign status.item_last = last_ff;
   assign status.rsp_busy  = rsp_valid_ff && rsp_stall;

   // read data of the current source store and its digit for this pass
   assign rd_word = cmd.src_bank ? rd1_ff : rd0_ff;
   assign dg      = rd_word[{cmd.pass, 2'b00} +: DIGIT_W];
   assign dg_ok   = dg < DIGIT_W'(RADIX);
   assign cnt_sel = cmd.pfx_step ? cmd.pfx_digit : dg;
   assign cnt_rd  = (cnt_sel < DIGIT_W'(RADIX)) ? counts_ff[cnt_sel] : '0;

   always_ff @(posedge clock) begin
      if (cmd.clr_cnt) begin
         for (int d = 0; d < RADIX; d++) counts_ff[d] <= '0;
         acc_ff <= '0;
      end else if (cmd.pfx_step) begin
         // exclusive prefix: counter becomes the first slot of its digit
         counts_ff[cmd.pfx_digit] <= acc_ff;
         acc_ff                   <= acc_ff + cnt_rd;
      end else if ((rd_cnt_ff || rd_sct_ff) && dg_ok) begin
         counts_ff[dg] <= cnt_rd + CW'(1);
      end
   end

   assign rd_en = cmd.rd_cnt || cmd.rd_sct || cmd.rd_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff  <= 1'b0;
         rd_sct_ff  <= 1'b0;
         rd_out_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         rd_cnt_ff  <= cmd.rd_cnt;
         rd_sct_ff  <= cmd.rd_sct;
         rd_out_ff  <= cmd.rd_out;
         rd_last_ff <= cmd.out_last;
      end
   end

   // store 0 takes loads and scatters from store 1; store 1 takes scatters from store 0
   assign we0 = (cmd.wr_load && room) || (rd_sct_ff && dg_ok && cmd.src_bank);
   assign wa0 = cmd.wr_load ? item_cnt_ff[AW-1:0] : cnt_rd[AW-1:0];
   assign wd0 = cmd.wr_load ? load_bcd : rd_word;
   assign we1 = rd_sct_ff && dg_ok && !cmd.src_bank;

   always_ff @(posedge clock) begin
      if (we0) bank0[wa0] <= wd0;
      if (rd_en) rd0_ff <= bank0[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we1) bank1[cnt_rd[AW-1:0]] <= rd_word;
      if (rd_en) rd1_ff <= bank1[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rd_out_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_out_ff) begin
         rsp_value_ff   <= bcd_to_bin(rd_word);
         rsp_last_ff    <= rd_last_ff;
         rsp_dropped_ff <= ovf_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_last_res  = rsp_last_ff;
   assign rsp_dropped   = rsp_dropped_ff;

endmodule

// ----- rtl/core/decimal_lsd_radix_sorter_top.sv -----
// Each loaded item goes through take, split and BCD write; the next item is taken
// only after that write. Sort after the last item: DIGIT_PASSES passes over the n
// held items, each pass being clear, count, prefix over ten counters, scatter.
// Output: one store read in flight at a time; a read issues once the output register frees.
// Reset clears the sequencer, item count, overflow flag and output valid;
// the element stores need no clearing.
// ----------------------------------------------------------------------------
// decimal_lsd_radix_sorter_top
// Base-10 LSD radix sorter: collects up to MAX_ITEMS values, sorts them with
// stable counting passes and returns the run in ascending order.
// ----------------------------------------------------------------------------
module decimal_lsd_radix_sorter_top
   import dlrs_pkg::*;
#(
   parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
   parameter int DIGIT_PASSES = DIGIT_PASSES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_value_res,
   output logic               rsp_last_res,
   output logic               rsp_dropped
);

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);

   dlrs_cmd_type    cmd;
   dlrs_status_type status;
   logic [CW-1:0]   item_count;
   logic [AW-1:0]   rd_addr;

   dlrs_ctrl #(
      .MAX_ITEMS    (MAX_ITEMS),
      .DIGIT_PASSES (DIGIT_PASSES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .item_count (item_count),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   dlrs_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_dropped   (rsp_dropped),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .item_count    (item_count),
      .status        (status)
   );

endmodule
